// File: design/evf_pkg.sv
// shared types and constants for the encoder velocity fusion block
package evf_pkg;
    localparam int AXES_DEF = 4;
    localparam int NARROW_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_NUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 3'd4;

    localparam logic [1:0] OP_LATCH = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_ENABLE = 2'd2;

    localparam logic [31:0] SERVO_PERIOD_RST = 32'd1000000;
    localparam logic [23:0] SLOW_NUM_RST = 24'd400000;
    localparam logic [15:0] FAST_THRESH_RST = 16'd2;
    localparam logic [7:0] STALE_LIMIT_RST = 8'd200;
    localparam logic [7:0] STALE_MAX = 8'hFF;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // divider operand and step counter widths
    localparam int DIV_W = 64;
    localparam int DIV_CNT_W = 7;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // take in the transaction, decode
        logic mul_lo;     // first partial product
        logic mul_hi;     // second partial product
        logic div_start;  // launch the divider
        logic div_step;   // one divider iteration
        logic commit;     // write back the axis state and result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_fast_div;
        logic need_slow_div;
        logic div_done;
    } t_stat;
endpackage

// File: design/evf_ctrl.sv
// controller state machine sequencing one transaction through the datapath
module evf_ctrl
    import evf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL_LO, S_MUL_HI, S_DIV_GO, S_DIV, S_COMMIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                if (i_stat.need_fast_div) begin
                    o_cmd.mul_lo = 1'b1;
                    n_state = S_MUL_HI;
                end else if (i_stat.need_slow_div) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: design/evf_div.sv
// restoring serial divider, one quotient bit per cycle while i_step is asserted
module evf_div
    import evf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [31:0]       i_divisor,
    output logic [DIV_W-1:0]  o_quot,
    output logic              o_done
);
    logic [DIV_W-1:0] r_quot;
    logic [31:0]      r_rem;
    logic [31:0]      r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [32:0]      w_trial;
    logic [32:0]      w_sub;

    assign w_trial = {r_rem, r_quot[DIV_W-1]};
    assign w_sub = w_trial - {1'b0, r_dsr};
    assign o_quot = r_quot;
    assign o_done = (r_cnt == DIV_CNT_W'(DIV_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (i_step) begin
            if (!w_sub[32]) begin
                r_rem <= w_sub[31:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[31:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b0};
            end
        end
    end
endmodule

// File: design/evf_dp.sv
// datapath: per-axis state, configuration registers, multiply and divide
module evf_dp
    import evf_pkg::*;
#(
    parameter int AXES = AXES_DEF,
    parameter int NARROW_BITS = NARROW_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_op,
    input  logic [1:0]            i_axis,
    input  logic [31:0]           i_counter_value,
    input  logic [15:0]           i_capture_time,
    input  logic                  i_count_down,
    input  logic                  i_enable_value,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [1:0]            o_axis_out,
    output logic [31:0]           o_position,
    output logic [31:0]           o_velocity,
    output logic [31:0]           o_delta_velocity,
    output logic [31:0]           o_period_velocity,
    output logic [4:0]            o_status
);
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    // configuration
    logic [31:0]   r_servo;
    logic [AXES-1:0] r_nmask;
    logic [23:0]   r_snum;
    logic [15:0]   r_fthr;
    logic [7:0]    r_slim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo <= SERVO_PERIOD_RST;
            r_nmask <= AXES'(12);
            r_snum <= SLOW_NUM_RST;
            r_fthr <= FAST_THRESH_RST;
            r_slim <= STALE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SERVO_PERIOD: if (i_cfg_data != '0) r_servo <= i_cfg_data;
                REG_NARROW_MASK: r_nmask <= AXES'(i_cfg_data[3:0]);
                REG_SLOW_NUM: r_snum <= i_cfg_data[23:0];
                REG_FAST_THRESH: r_fthr <= i_cfg_data[15:0];
                REG_STALE_LIMIT: r_slim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // per-axis state
    logic [AXES-1:0] r_en, r_seen;
    logic [31:0] r_prev [AXES];
    logic [31:0] r_pos  [AXES];
    logic [31:0] r_fv   [AXES];
    logic [31:0] r_sv   [AXES];
    logic [31:0] r_uv   [AXES];
    logic [15:0] r_lct  [AXES];
    logic [7:0]  r_stc  [AXES];
    logic [4:0]  r_st   [AXES];

    // latched transaction
    logic [1:0]  r_op, r_axis;
    logic [31:0] r_cur;
    logic [15:0] r_t;
    logic        r_down, r_env, r_valid_ax;
    logic [AW-1:0] r_a;

    // decoded values
    logic [31:0] r_delta;    // wrapped delta, signed
    logic [31:0] r_mag;      // |delta|
    logic [15:0] r_ticks;
    logic [63:0] r_prod;     // |delta| * 1e9

    logic [31:0] w_d, w_nd, w_delta, w_mag;
    logic [AW-1:0] w_a;
    logic        w_valid_ax;
    logic [63:0] w_quot;
    logic        w_div_done, w_need_fast, w_need_slow;
    logic [45:0] w_prod_lo, w_prod_hi;

    assign w_valid_ax = ({30'd0, i_axis} < AXES);
    assign w_a = AW'(i_axis);
    assign w_d = i_counter_value - r_prev[w_a];
    always_comb begin
        w_nd = w_d & ((32'd1 << NARROW_BITS) - 32'd1);
        if (w_d[NARROW_BITS-1]) w_nd = w_nd | ~((32'd1 << NARROW_BITS) - 32'd1);
        w_delta = r_nmask[w_a] ? w_nd : w_d;
        w_mag = w_delta[31] ? (32'd0 - w_delta) : w_delta;
    end

    evf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start), .i_step(i_cmd.div_step),
        .i_dividend(r_op == OP_LATCH ? r_prod : {40'd0, r_snum}),
        .i_divisor(r_op == OP_LATCH ? r_servo : {16'd0, r_ticks}),
        .o_quot(w_quot), .o_done(w_div_done)
    );

    assign w_need_fast = r_valid_ax && (r_op == OP_LATCH) && r_en[r_a];
    assign w_need_slow = r_valid_ax && (r_op == OP_CAPTURE) && r_en[r_a]
                         && r_seen[r_a] && (r_ticks != 16'd0);
    assign o_stat = {w_need_fast, w_need_slow, w_div_done};

    // 32x30 product split in two 16-bit halves of the multiplier
    assign w_prod_lo = {30'd0, r_mag[15:0]} * {16'd0, NS_PER_SEC};
    assign w_prod_hi = {30'd0, r_mag[31:16]} * {16'd0, NS_PER_SEC};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_axis <= i_axis; r_cur <= i_counter_value;
            r_t <= i_capture_time; r_down <= i_count_down; r_env <= i_enable_value;
            r_valid_ax <= w_valid_ax; r_a <= w_a;
            r_delta <= w_delta; r_mag <= w_mag;
            r_ticks <= i_capture_time - r_lct[w_a];
        end
        if (i_cmd.mul_lo) r_prod <= {18'd0, w_prod_lo};
        if (i_cmd.mul_hi) r_prod <= r_prod + {2'd0, w_prod_hi, 16'd0};
    end

    // saturated signed fast velocity and signed slow velocity from the quotient
    logic [31:0] w_fast_sat, w_slow_val;
    always_comb begin
        if (!r_delta[31])
            w_fast_sat = (w_quot > 64'h7FFFFFFF) ? 32'h7FFFFFFF : w_quot[31:0];
        else
            w_fast_sat = (w_quot > 64'h80000000) ? 32'h80000000 : (32'd0 - w_quot[31:0]);
        w_slow_val = r_down ? (32'd0 - w_quot[31:0]) : w_quot[31:0];
    end

    logic [7:0] w_stc_inc;
    logic w_fresh, w_use_fast;
    assign w_stc_inc = (r_stc[r_a] < STALE_MAX) ? r_stc[r_a] + 8'd1 : r_stc[r_a];
    assign w_fresh = w_stc_inc < r_slim;
    assign w_use_fast = r_mag >= {16'd0, r_fthr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '1;
            r_seen <= '0;
            for (int k = 0; k < AXES; k++) begin
                r_prev[k] <= '0; r_pos[k] <= '0; r_fv[k] <= '0; r_sv[k] <= '0;
                r_uv[k] <= '0; r_lct[k] <= '0; r_stc[k] <= STALE_LIMIT_RST;
                r_st[k] <= 5'd1;
            end
        end else if (i_cmd.commit && r_valid_ax) begin
            case (r_op)
                OP_LATCH: begin
                    r_prev[r_a] <= r_cur;
                    if (!r_en[r_a]) begin
                        r_st[r_a] <= '0; r_fv[r_a] <= '0; r_sv[r_a] <= '0;
                        r_uv[r_a] <= '0;
                    end else begin
                        r_pos[r_a] <= r_pos[r_a] + r_delta;
                        r_fv[r_a] <= w_fast_sat;
                        r_stc[r_a] <= w_stc_inc;
                        r_st[r_a] <= {!w_use_fast && w_fresh, w_use_fast, w_fresh,
                                      r_seen[r_a], 1'b1};
                        if (w_use_fast) r_uv[r_a] <= w_fast_sat;
                        else if (w_fresh) r_uv[r_a] <= r_sv[r_a];
                        else begin
                            r_sv[r_a] <= '0; r_uv[r_a] <= '0;
                        end
                    end
                end
                OP_CAPTURE: begin
                    if (r_en[r_a]) begin
                        if (w_need_slow) begin
                            r_sv[r_a] <= w_slow_val;
                            r_stc[r_a] <= '0;
                        end
                        r_lct[r_a] <= r_t;
                        r_seen[r_a] <= 1'b1;
                    end
                end
                OP_ENABLE: begin
                    r_en[r_a] <= r_env; r_st[r_a] <= {4'd0, r_env};
                    r_fv[r_a] <= '0; r_sv[r_a] <= '0; r_uv[r_a] <= '0;
                    r_stc[r_a] <= r_slim; r_seen[r_a] <= 1'b0;
                    r_prev[r_a] <= r_cur; r_lct[r_a] <= '0;
                end
                default: ;
            endcase
        end
    end

    // result read from the state once committed
    assign o_axis_out = r_axis;
    assign o_position = r_valid_ax ? r_pos[r_a] : '0;
    assign o_velocity = r_valid_ax ? r_uv[r_a] : '0;
    assign o_delta_velocity = r_valid_ax ? r_fv[r_a] : '0;
    assign o_period_velocity = r_valid_ax ? r_sv[r_a] : '0;
    assign o_status = r_valid_ax ? r_st[r_a] : '0;
endmodule

// File: design/encoder_velocity_fusion_core.sv
// top level of the encoder velocity fusion block
// Multi-axis quadrature encoder velocity estimator. Each input transaction
// (latch, capture or enable) updates one axis and yields exactly one result
// transaction with that axis's position, fused/fast/slow velocity and status.
// One transaction is processed at a time: a latch on an enabled axis and a
// capture with a valid interval run through the shared 64-step serial
// divider; other transactions bypass it. The input is ready again once the
// result has been taken.
module encoder_velocity_fusion_core
    import evf_pkg::*;
#(
    parameter int AXES = AXES_DEF,
    parameter int NARROW_BITS = NARROW_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: op[1:0], axis[3:2], counter_value[35:4], capture_time[51:36],
    //        count_down[52], enable_value[53], zero fill
    input  logic [55:0]           s_axis_tdata,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: axis_out[1:0], position[33:2], velocity[65:34],
    //        delta velocity[97:66], period velocity[129:98], status[134:130],
    //        zero fill
    output logic [135:0]          m_axis_tdata
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [1:0]  w_axis_out;
    logic [31:0] w_pos, w_vel, w_vf, w_vs;
    logic [4:0]  w_status;

    evf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    evf_dp #(.AXES(AXES), .NARROW_BITS(NARROW_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_op(s_axis_tdata[1:0]), .i_axis(s_axis_tdata[3:2]),
        .i_counter_value(s_axis_tdata[35:4]), .i_capture_time(s_axis_tdata[51:36]),
        .i_count_down(s_axis_tdata[52]), .i_enable_value(s_axis_tdata[53]),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_axis_out(w_axis_out), .o_position(w_pos), .o_velocity(w_vel),
        .o_delta_velocity(w_vf), .o_period_velocity(w_vs), .o_status(w_status)
    );

    assign m_axis_tdata = {1'b0, w_status, w_vs, w_vf, w_vel, w_pos, w_axis_out};
endmodule

// File: verif/encoder_velocity_fusion_core_tb.sv
// testbench for the encoder velocity fusion block: self-checking with a state predictor
module encoder_velocity_fusion_core_tb
    import evf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_AXES = 4;
    localparam int NBITS = 16;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  axis_out;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] delta_velocity;
        logic [31:0] period_velocity;
        logic [4:0]  status;
    } t_axis_report;

    int mismatch_count = 0;

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // predictor of the velocity estimator plus queue of pending reports
    class velocity_scoreboard;
        logic [31:0] servo_period;
        logic [3:0]  narrow_mask;
        logic [23:0] slow_num;
        logic [15:0] fast_thresh;
        logic [7:0]  stale_lim;
        logic        enabled   [N_AXES];
        logic [31:0] prev_cnt  [N_AXES];
        logic [31:0] pos_acc   [N_AXES];
        logic [31:0] vel_fast  [N_AXES];
        logic [31:0] vel_slow  [N_AXES];
        logic [31:0] vel_fused [N_AXES];
        logic [15:0] last_cap  [N_AXES];
        logic        cap_seen  [N_AXES];
        logic [7:0]  stale_cnt [N_AXES];
        logic [4:0]  axis_stat [N_AXES];
        t_axis_report pending_reports[$];

        function new();
            servo_period = SERVO_PERIOD_RST;
            narrow_mask = 4'd12;
            slow_num = SLOW_NUM_RST;
            fast_thresh = FAST_THRESH_RST;
            stale_lim = STALE_LIMIT_RST;
            for (int a = 0; a < N_AXES; a++) begin
                enabled[a] = 1'b1; prev_cnt[a] = '0; pos_acc[a] = '0;
                vel_fast[a] = '0; vel_slow[a] = '0; vel_fused[a] = '0;
                last_cap[a] = '0; cap_seen[a] = 1'b0; stale_cnt[a] = STALE_LIMIT_RST;
                axis_stat[a] = 5'd1;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_SERVO_PERIOD: if (val != '0) servo_period = val;
                REG_NARROW_MASK:  narrow_mask = val[3:0];
                REG_SLOW_NUM:     slow_num = val[23:0];
                REG_FAST_THRESH:  fast_thresh = val[15:0];
                REG_STALE_LIMIT:  stale_lim = val[7:0];
                default: ;
            endcase
        endfunction

        function void latch_axis(int a, logic [31:0] cur);
            logic [31:0] d;
            longint delta, q, mag;
            logic [4:0] st;
            logic fresh;
            if (!enabled[a]) begin
                axis_stat[a] = '0; prev_cnt[a] = cur;
                vel_fast[a] = '0; vel_slow[a] = '0; vel_fused[a] = '0;
                return;
            end
            st = 5'd1;
            d = cur - prev_cnt[a];
            if (narrow_mask[a]) begin
                d = d & 32'h0000_FFFF;
                delta = d[NBITS-1] ? longint'(d) - 64'sd65536 : longint'(d);
            end else begin
                delta = longint'(signed'(d));
            end
            pos_acc[a] = pos_acc[a] + delta[31:0];
            prev_cnt[a] = cur;
            q = (delta * 64'sd1000000000) / longint'({32'd0, servo_period});
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            vel_fast[a] = q[31:0];
            if (cap_seen[a]) st[1] = 1'b1;
            if (stale_cnt[a] != STALE_MAX) stale_cnt[a]++;
            fresh = stale_cnt[a] < stale_lim;
            if (fresh) st[2] = 1'b1;
            mag = delta < 0 ? -delta : delta;
            if (mag >= longint'(fast_thresh)) begin
                vel_fused[a] = vel_fast[a]; st[3] = 1'b1;
            end else if (fresh) begin
                vel_fused[a] = vel_slow[a]; st[4] = 1'b1;
            end else begin
                vel_slow[a] = '0; vel_fused[a] = '0;
            end
            axis_stat[a] = st;
        endfunction

        // notes an accepted input transaction and queues its expected report
        function void note_input(logic [55:0] word);
            logic [1:0] op;
            int a;
            logic [31:0] cur, v;
            logic [15:0] t, ticks;
            logic down, en;
            t_axis_report r;
            op = word[1:0]; a = int'(word[3:2]); cur = word[35:4]; t = word[51:36];
            down = word[52]; en = word[53];
            r = '0;
            r.axis_out = word[3:2];
            if (a < N_AXES) begin
                case (op)
                    OP_LATCH: latch_axis(a, cur);
                    OP_CAPTURE: if (enabled[a]) begin
                        if (cap_seen[a]) begin
                            ticks = t - last_cap[a];
                            if (ticks != '0) begin
                                v = {8'd0, slow_num} / {16'd0, ticks};
                                vel_slow[a] = down ? (32'd0 - v) : v;
                                stale_cnt[a] = '0;
                            end
                        end
                        last_cap[a] = t; cap_seen[a] = 1'b1;
                    end
                    OP_ENABLE: begin
                        enabled[a] = en; axis_stat[a] = {4'd0, en};
                        vel_fast[a] = '0; vel_slow[a] = '0; vel_fused[a] = '0;
                        stale_cnt[a] = stale_lim; cap_seen[a] = 1'b0;
                        prev_cnt[a] = cur; last_cap[a] = '0;
                    end
                    default: ;
                endcase
                r.position = pos_acc[a]; r.velocity = vel_fused[a];
                r.delta_velocity = vel_fast[a]; r.period_velocity = vel_slow[a];
                r.status = axis_stat[a];
            end
            pending_reports.push_back(r);
        endfunction

        // compares one accepted result with the oldest expectation
        task check_result(logic [135:0] word);
            t_axis_report e;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result", word[31:0], 32'd0);
                return;
            end
            e = pending_reports.pop_front();
            if (word[1:0] != e.axis_out)
                report_mismatch("axis_out", 32'(word[1:0]), 32'(e.axis_out));
            if (word[33:2] != e.position) report_mismatch("position", word[33:2], e.position);
            if (word[65:34] != e.velocity) report_mismatch("velocity", word[65:34], e.velocity);
            if (word[97:66] != e.delta_velocity)
                report_mismatch("delta velocity", word[97:66], e.delta_velocity);
            if (word[129:98] != e.period_velocity)
                report_mismatch("period velocity", word[129:98], e.period_velocity);
            if (word[134:130] != e.status)
                report_mismatch("status", 32'(word[134:130]), 32'(e.status));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: op, axis, counter_value, capture_time, count_down, enable_value
    logic [55:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: axis_out, position, velocity, delta velocity, period velocity, status
    logic [135:0]          m_axis_tdata;

    velocity_scoreboard sb;
    int send_idle_pct = 35;   // sender gap chance in percent
    int recv_stall_pct = 81;  // receiver stall chance in percent
    longint cycle_count = 0;

    encoder_velocity_fusion_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run guard: hard cycle ceiling
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("encoder_velocity_fusion_core_tb: FAIL");
            $finish;
        end
    end

    // output side: random stalls, every accepted result is checked
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // per-axis counter tracking so most latches have small, meaningful deltas
    logic [31:0] axis_counter [N_AXES];
    logic [15:0] axis_time    [N_AXES];

    // sends one transaction, with a random gap first, and waits for acceptance;
    // valid stays high afterwards until the next gap or a drain drops it
    task automatic send_item(input logic [1:0] op, input logic [1:0] ax,
                             input logic [31:0] cnt, input logic [15:0] t,
                             input logic down, input logic en);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, en, down, t, cnt, ax, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input({2'b00, en, down, t, cnt, ax, op});
    endtask

    // waits until all expected results are in, then lets the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // well-formed random traffic: tracked counters and timestamps, some noise
    task automatic random_item();
        logic [1:0] ax;
        int pick;
        logic [31:0] step;
        ax = 2'($urandom_range(3));
        pick = int'($urandom_range(99));
        if (pick < 45) begin
            case ($urandom_range(5))
                0: step = 32'd0;
                1: step = $urandom_range(2) - 32'd1;
                2: step = $urandom_range(40) - 32'd20;
                3: step = $urandom_range(4000) - 32'd2000;
                4: step = $urandom;
                default: step = $urandom_range(70000) - 32'd35000;
            endcase
            axis_counter[ax] = axis_counter[ax] + step;
            send_item(OP_LATCH, ax, axis_counter[ax], 16'($urandom), 1'($urandom),
                      1'($urandom));
        end else if (pick < 85) begin
            case ($urandom_range(3))
                0: axis_time[ax] = axis_time[ax] + 16'($urandom_range(1, 50));
                1: axis_time[ax] = axis_time[ax] + 16'($urandom_range(1, 3000));
                2: axis_time[ax] = 16'($urandom);
                default: ;  // repeated timestamp gives zero interval
            endcase
            send_item(OP_CAPTURE, ax, $urandom, axis_time[ax], 1'($urandom),
                      1'($urandom));
        end else if (pick < 95) begin
            axis_counter[ax] = $urandom;
            send_item(OP_ENABLE, ax, axis_counter[ax], 16'($urandom), 1'($urandom),
                      $urandom_range(99) < 75);
        end else begin
            send_item(OP_RESERVED, ax, $urandom, 16'($urandom), 1'($urandom),
                      1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        for (int a = 0; a < N_AXES; a++) begin
            axis_counter[a] = '0; axis_time[a] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, narrow and wide wrap, extremes, captures, ops
        send_item(OP_LATCH, 2'd0, 32'd5, 16'd0, 1'b0, 1'b0);
        send_item(OP_LATCH, 2'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_LATCH, 2'd0, 32'h7FFF_FFFF, 16'd0, 1'b0, 1'b0);
        send_item(OP_LATCH, 2'd2, 32'h0001_8000, 16'd0, 1'b0, 1'b0);
        send_item(OP_LATCH, 2'd3, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
        send_item(OP_CAPTURE, 2'd1, 32'd0, 16'd100, 1'b0, 1'b0);
        send_item(OP_CAPTURE, 2'd1, 32'd0, 16'd100, 1'b0, 1'b0);
        send_item(OP_CAPTURE, 2'd1, 32'd0, 16'd101, 1'b1, 1'b0);
        send_item(OP_CAPTURE, 2'd1, 32'd0, 16'd50, 1'b0, 1'b0);
        send_item(OP_LATCH, 2'd1, 32'd1, 16'd0, 1'b0, 1'b0);
        send_item(OP_LATCH, 2'd1, 32'd1, 16'd0, 1'b0, 1'b0);
        send_item(OP_ENABLE, 2'd3, 32'd77, 16'd0, 1'b0, 1'b0);
        send_item(OP_CAPTURE, 2'd3, 32'd0, 16'd9, 1'b1, 1'b1);
        send_item(OP_LATCH, 2'd3, 32'd90, 16'd0, 1'b0, 1'b0);
        send_item(OP_ENABLE, 2'd3, 32'hFFFF_0000, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_RESERVED, 2'd2, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
        drain();

        // extreme settings: shortest period saturates fast velocity
        write_cfg(REG_SERVO_PERIOD, 32'd1);
        write_cfg(REG_SERVO_PERIOD, 32'd0);
        write_cfg(REG_NARROW_MASK, 32'd15);
        write_cfg(REG_SLOW_NUM, 32'hFFFF_FFFF);
        write_cfg(REG_FAST_THRESH, 32'd65535);
        write_cfg(REG_STALE_LIMIT, 32'd255);
        for (int a = 0; a < N_AXES; a++) axis_counter[a] = sb.prev_cnt[a];
        repeat (150) random_item();
        drain();

        write_cfg(REG_SERVO_PERIOD, 32'hFFFF_FFFF);
        write_cfg(REG_NARROW_MASK, 32'd0);
        write_cfg(REG_SLOW_NUM, 32'd1);
        write_cfg(REG_FAST_THRESH, 32'd1);
        write_cfg(REG_STALE_LIMIT, 32'd0);
        repeat (150) random_item();
        drain();

        // mid settings across the three idling phases
        write_cfg(REG_SERVO_PERIOD, 32'd250000);
        write_cfg(REG_NARROW_MASK, 32'd5);
        write_cfg(REG_SLOW_NUM, 32'd400000);
        write_cfg(REG_FAST_THRESH, 32'd30);
        write_cfg(REG_STALE_LIMIT, 32'd6);
        repeat (400) random_item();
        drain();

        send_idle_pct = 81; recv_stall_pct = 35;
        write_cfg(REG_FAST_THRESH, 32'd4);
        write_cfg(REG_STALE_LIMIT, 32'd20);
        repeat (400) random_item();
        drain();

        send_idle_pct = 0; recv_stall_pct = 0;
        write_cfg(REG_SERVO_PERIOD, 32'd1000000);
        repeat (350) random_item();
        drain();

        if (mismatch_count == 0 && sb.pending_reports.size() == 0) begin
            $display("encoder_velocity_fusion_core_tb: PASS");
        end else begin
            $display("encoder_velocity_fusion_core_tb: FAIL");
        end
        $finish;
    end
endmodule
